// File: hdl/key_matrix_debouncer_unit_macros.svh
// Assertion macros for the key matrix debouncer.
// Used by key_matrix_debouncer_unit; expects clk_i and rst_ni in scope.
`ifndef KEY_MATRIX_DEBOUNCER_UNIT_MACROS_SVH
`define KEY_MATRIX_DEBOUNCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define KMD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kmd assertion failed");
`define KMD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("kmd next-cycle assertion failed");
`else
`define KMD_ASSERT(name, prop)
`define KMD_ASSERT_NEXT(name, pre, post)
`endif

`endif

// File: hdl/kmd_pkg.sv
// Shared constants, types and helpers for the key matrix debouncer.
// No dependencies.
package kmd_pkg;

  localparam int unsigned ROWS      = 5;
  localparam int unsigned COLS      = 16;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned COL_W     = 4;
  localparam int unsigned CDATA_W   = 16;
  localparam int unsigned SCAN_W    = 8;
  localparam int unsigned KCNT_W    = 7;
  localparam int unsigned ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned COL_IDX_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned CNT_W     = $clog2(ROWS * COLS + 1);
  localparam logic [SCAN_W-1:0] SCANS_RESET = SCAN_W'(5);
  localparam logic [CNT_W:0]    KCNT_MAX    = (CNT_W + 1)'((1 << KCNT_W) - 1);

  typedef enum logic {
    MODE_SAMPLE   = 1'b0,
    MODE_PASS_END = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [CDATA_W-1:0] cols;
  } step_t;

  typedef struct packed {
    logic [CDATA_W-1:0] stable_row;
    logic               key_on;
    logic [KCNT_W-1:0]  key_count;
    logic               settled;
    logic               bounce;
    logic               committed;
  } result_t;

  function automatic logic [CNT_W-1:0] popcnt(input logic [COLS-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < COLS; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// File: hdl/kmd_store.sv
// Raw and stable row stores, global countdown and per-beat result logic.
// Depends on kmd_pkg.
module kmd_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_en_i,
  input  kmd_pkg::step_t            step_i,
  input  logic                      cfg_we_i,
  input  logic [kmd_pkg::SCAN_W-1:0] cfg_wdata_i,
  output kmd_pkg::result_t          res_o
);
  import kmd_pkg::*;

  logic [COLS-1:0]   raw_q    [ROWS];
  logic [COLS-1:0]   stable_q [ROWS];
  logic [SCAN_W-1:0] cnt_q, cnt_d;
  logic [SCAN_W-1:0] scans_q;
  logic [CNT_W-1:0]  raw_cnt_q, raw_cnt_d;
  logic [CNT_W-1:0]  stb_cnt_q;

  logic                 row_ok;
  logic [ROW_IDX_W-1:0] ridx;
  logic [COLS-1:0]      cols_m;
  logic [COLS-1:0]      raw_rd;
  logic [COLS-1:0]      stb_rd;
  logic                 change;
  logic                 commit;
  logic                 bounce;
  logic [COLS-1:0]      srow;
  logic [CNT_W-1:0]     cnt_view;

  assign row_ok = (32'(step_i.row) < ROWS);
  assign ridx   = step_i.row[ROW_IDX_W-1:0];
  assign cols_m = step_i.cols[COLS-1:0];
  assign raw_rd = row_ok ? raw_q[ridx] : '0;
  assign stb_rd = row_ok ? stable_q[ridx] : '0;

  always_comb begin
    cnt_d     = cnt_q;
    raw_cnt_d = raw_cnt_q;
    change    = 1'b0;
    commit    = 1'b0;
    bounce    = 1'b0;
    unique case (step_i.mode)
      MODE_SAMPLE: begin
        if (row_ok && (raw_rd != cols_m)) begin
          change    = 1'b1;
          bounce    = (cnt_q != '0);
          cnt_d     = (scans_q != '0) ? scans_q : SCAN_W'(1);
          raw_cnt_d = raw_cnt_q - popcnt(raw_rd) + popcnt(cols_m);
        end
      end
      MODE_PASS_END: begin
        if (cnt_q != '0) begin
          cnt_d  = cnt_q - SCAN_W'(1);
          commit = (cnt_q == SCAN_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= SCANS_RESET;
      scans_q   <= SCANS_RESET;
      raw_cnt_q <= '0;
      stb_cnt_q <= '0;
      for (int i = 0; i < ROWS; i++) begin
        raw_q[i]    <= '0;
        stable_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        scans_q <= cfg_wdata_i;
      end
      if (step_en_i) begin
        cnt_q     <= cnt_d;
        raw_cnt_q <= raw_cnt_d;
        if (change) begin
          raw_q[ridx] <= cols_m;
        end
        if (commit) begin
          stb_cnt_q <= raw_cnt_q;
          for (int i = 0; i < ROWS; i++) begin
            stable_q[i] <= raw_q[i];
          end
        end
      end
    end
  end

  // stable view after this beat: a commit exposes the raw store directly
  assign srow     = commit ? raw_rd : stb_rd;
  assign cnt_view = commit ? raw_cnt_q : stb_cnt_q;

  always_comb begin
    res_o            = '0;
    res_o.stable_row = CDATA_W'(srow);
    res_o.key_on     = row_ok && (32'(step_i.col) < COLS) && srow[step_i.col[COL_IDX_W-1:0]];
    res_o.key_count  = ({1'b0, cnt_view} > KCNT_MAX) ? KCNT_MAX[KCNT_W-1:0]
                                                      : KCNT_W'(cnt_view);
    res_o.settled    = (cnt_d == '0);
    res_o.bounce     = bounce;
    res_o.committed  = commit;
  end

endmodule

// File: hdl/key_matrix_debouncer_unit.sv
// Key matrix debouncer, top level: handshake and result register.
// Depends on kmd_pkg, kmd_store and key_matrix_debouncer_unit_macros.svh.
// Results are registered: a result is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; input stalls only while the result register is full and stalled.
// Reset: rows and stable matrix clear, countdown and debounce_scans load 5, no result pending.
`include "key_matrix_debouncer_unit_macros.svh"
module key_matrix_debouncer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kmd_pkg::SCAN_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [kmd_pkg::ROW_W-1:0]   row_i,
  input  logic [kmd_pkg::COL_W-1:0]   col_i,
  input  logic [kmd_pkg::CDATA_W-1:0] cols_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kmd_pkg::CDATA_W-1:0] stable_row_o,
  output logic                        key_on_o,
  output logic [kmd_pkg::KCNT_W-1:0]  key_count_o,
  output logic                        settled_o,
  output logic                        bounce_o,
  output logic                        committed_o
);
  import kmd_pkg::*;

  logic    accept;
  step_t   step;
  result_t res;
  result_t res_q;
  logic    out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    step.mode = mode_e'(mode_i);
    step.row  = row_i;
    step.col  = col_i;
    step.cols = cols_i;
  end

  kmd_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (accept),
    .step_i      (step),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign stable_row_o = res_q.stable_row;
  assign key_on_o     = res_q.key_on;
  assign key_count_o  = res_q.key_count;
  assign settled_o    = res_q.settled;
  assign bounce_o     = res_q.bounce;
  assign committed_o  = res_q.committed;

  `KMD_ASSERT(a_full_stall, (out_valid_o && out_stall_i) |-> in_stall_o)
  `KMD_ASSERT(a_commit_settled, (out_valid_o && committed_o) |-> settled_o)
  `KMD_ASSERT(a_bounce_xor_commit, out_valid_o |-> !(bounce_o && committed_o))
  `KMD_ASSERT_NEXT(a_accept_valid, accept, out_valid_o)

endmodule

// File: dv/key_matrix_debouncer_unit_test.sv
// Self-checking testbench for key_matrix_debouncer_unit: scan passes, chatter and noise beats,
// checked against an in-bench debounce predictor. Needs only kmd_pkg and the RTL.
module key_matrix_debouncer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kmd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 64;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [SCAN_W-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                mode_i      = 1'b0;
  logic [ROW_W-1:0]    row_i       = '0;
  logic [COL_W-1:0]    col_i       = '0;
  logic [CDATA_W-1:0]  cols_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CDATA_W-1:0]  stable_row_o;
  logic                key_on_o;
  logic [KCNT_W-1:0]   key_count_o;
  logic                settled_o;
  logic                bounce_o;
  logic                committed_o;

  key_matrix_debouncer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .cols_i       (cols_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .stable_row_o (stable_row_o),
    .key_on_o     (key_on_o),
    .key_count_o  (key_count_o),
    .settled_o    (settled_o),
    .bounce_o     (bounce_o),
    .committed_o  (committed_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [CDATA_W-1:0] keymap_raw    [ROWS];
  logic [CDATA_W-1:0] keymap_stable [ROWS];
  logic [SCAN_W-1:0]  settle_cnt;
  logic [SCAN_W-1:0]  scans_cfg;

  step_t   beats_to_send [$];
  result_t views_due     [$];
  step_t   beat_cur;
  result_t view_want;

  logic [CDATA_W-1:0] keys_now [ROWS];
  int unsigned in_gap_max  = 0;
  int unsigned out_gap_max = 0;
  int unsigned in_wait     = 0;
  int unsigned out_wait    = 0;
  int unsigned hold_ask    = 0;
  int unsigned hold_done   = 0;
  int unsigned hold_left   = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned beats_queued  = 0;
  int unsigned beats_in      = 0;
  int unsigned views_checked = 0;
  int unsigned commits_seen  = 0;
  int unsigned bounces_seen  = 0;
  int unsigned fails         = 0;

  function automatic result_t debounce_step(step_t s);
    result_t     r;
    int unsigned n;
    r = '0;
    n = 0;
    if (s.mode == MODE_SAMPLE) begin
      if (s.row < ROWS) begin
        if (keymap_raw[s.row] != s.cols) begin
          keymap_raw[s.row] = s.cols;
          r.bounce = (settle_cnt != 0);
          settle_cnt = (scans_cfg != 0) ? scans_cfg : SCAN_W'(1);
        end
      end
    end else if (settle_cnt != 0) begin
      settle_cnt = settle_cnt - SCAN_W'(1);
      if (settle_cnt == 0) begin
        keymap_stable = keymap_raw;
        r.committed = 1'b1;
      end
    end
    if (s.row < ROWS) begin
      r.stable_row = keymap_stable[s.row];
      if (s.col < COLS) begin
        r.key_on = r.stable_row[s.col];
      end
    end
    for (int i = 0; i < ROWS; i++) begin
      for (int j = 0; j < COLS; j++) begin
        n += 32'(keymap_stable[i][j]);
      end
    end
    r.key_count = (n > (1 << KCNT_W) - 1) ? '1 : KCNT_W'(n);
    r.settled = (settle_cnt == 0);
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", fname, want_v, got_v);
      fails++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        views_due.push_back(debounce_step(beat_cur));
        beats_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid_i <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          beat_cur = beats_to_send.pop_front();
          in_valid_i <= 1'b1;
          mode_i     <= beat_cur.mode;
          row_i      <= beat_cur.row;
          col_i      <= beat_cur.col;
          cols_i     <= beat_cur.cols;
          in_wait = $urandom_range(in_gap_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (views_due.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          view_want = views_due.pop_front();
          check_field("stable_row", 32'(view_want.stable_row), 32'(stable_row_o));
          check_field("key_on", 32'(view_want.key_on), 32'(key_on_o));
          check_field("key_count", 32'(view_want.key_count), 32'(key_count_o));
          check_field("settled", 32'(view_want.settled), 32'(settled_o));
          check_field("bounce", 32'(view_want.bounce), 32'(bounce_o));
          check_field("committed", 32'(view_want.committed), 32'(committed_o));
          views_checked++;
          commits_seen += 32'(view_want.committed);
          bounces_seen += 32'(view_want.bounce);
        end
        out_wait = $urandom_range(out_gap_max);
      end
      if (hold_ask != hold_done) begin
        hold_done = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (out_wait > 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, views_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_beat(mode_e m, int unsigned r, int unsigned c, logic [CDATA_W-1:0] v);
    step_t s;
    s.mode = m;
    s.row  = ROW_W'(r);
    s.col  = COL_W'(c);
    s.cols = v;
    beats_to_send.push_back(s);
    beats_queued++;
  endtask

  task automatic add_noise_beat();
    add_beat(mode_e'($urandom_range(1)), $urandom_range(7), $urandom_range(15),
             CDATA_W'($urandom));
  endtask

  // one well-formed pass: every row sampled, then the pass-end beat
  task automatic add_scan_pass();
    for (int r = 0; r < ROWS; r++) begin
      if ($urandom_range(99) < 15) begin
        keys_now[r] ^= CDATA_W'(1) << $urandom_range(15);
      end
      if ($urandom_range(19) == 0) begin
        keys_now[r] = CDATA_W'($urandom);
      end
      add_beat(MODE_SAMPLE, r, $urandom_range(15), keys_now[r]);
    end
    add_beat(MODE_PASS_END, $urandom_range(7), $urandom_range(15), CDATA_W'($urandom));
  endtask

  // contact chatter: a row flips and flips back within one pass
  task automatic add_chatter();
    int unsigned r;
    r = $urandom_range(ROWS - 1);
    add_beat(MODE_SAMPLE, r, $urandom_range(15), keys_now[r] ^ CDATA_W'($urandom));
    add_beat(MODE_SAMPLE, r, $urandom_range(15), keys_now[r]);
    add_beat(MODE_PASS_END, r, $urandom_range(15), CDATA_W'($urandom));
  endtask

  task automatic add_random_mix(int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = beats_queued + count;
    while (beats_queued < stop_at) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        add_scan_pass();
      end else if (pick < 9) begin
        add_noise_beat();
      end else begin
        add_chatter();
      end
    end
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (beats_to_send.size() != 0 || in_valid_i || views_due.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_scans(logic [SCAN_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    scans_cfg = v;
    cfg_we_i  <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < ROWS; i++) begin
      keymap_raw[i]    = '0;
      keymap_stable[i] = '0;
      keys_now[i]      = '0;
    end
    settle_cnt = SCANS_RESET;
    scans_cfg  = SCANS_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset countdown, out-of-range rows, commit, queries, bounce
    in_gap_max  = 2;
    out_gap_max = 2;
    add_beat(MODE_SAMPLE, 0, 15, 16'hFFFF);
    add_beat(MODE_SAMPLE, 4, 0, 16'h8001);
    add_beat(MODE_SAMPLE, 5, 3, 16'hFFFF);
    add_beat(MODE_SAMPLE, 7, 15, 16'h1234);
    add_beat(MODE_PASS_END, 0, 0, 16'h0000);
    add_beat(MODE_PASS_END, 4, 15, 16'hFFFF);
    add_beat(MODE_PASS_END, 1, 8, 16'h5A5A);
    add_beat(MODE_PASS_END, 2, 1, 16'h0F0F);
    add_beat(MODE_PASS_END, 3, 2, 16'hF0F0);
    add_beat(MODE_PASS_END, 0, 15, 16'h0000);
    add_beat(MODE_PASS_END, 4, 15, 16'h0000);
    add_beat(MODE_PASS_END, 6, 0, 16'hFFFF);
    add_beat(MODE_SAMPLE, 0, 7, 16'hFFFF);
    add_beat(MODE_SAMPLE, 1, 0, 16'h0000);
    add_beat(MODE_SAMPLE, 2, 1, 16'hAAAA);
    add_beat(MODE_SAMPLE, 2, 0, 16'h5555);
    add_beat(MODE_SAMPLE, 3, 14, 16'h7FFE);
    add_beat(MODE_PASS_END, 2, 1, 16'h0000);
    add_beat(MODE_PASS_END, 3, 14, 16'hFFFF);
    keys_now[0] = 16'hFFFF;
    keys_now[2] = 16'h5555;
    keys_now[3] = 16'h7FFE;
    keys_now[4] = 16'h8001;
    wait_idle();

    // countdown still running here: new setting must not disturb it
    write_scans(8'd1);
    in_gap_max  = 11;
    out_gap_max = 11;
    add_random_mix(120);
    wait_idle();

    // zero setting, back-to-back input against a long output hold
    write_scans(8'd0);
    in_gap_max  = 0;
    out_gap_max = 11;
    hold_ask++;
    add_random_mix(100);
    wait_idle();

    write_scans(8'd255);
    in_gap_max  = 3;
    out_gap_max = 0;
    add_beat(MODE_SAMPLE, 2, 5, 16'h0000);
    add_beat(MODE_SAMPLE, 2, 5, 16'hFFFF);
    keys_now[2] = 16'hFFFF;
    for (int i = 0; i < 256; i++) begin
      add_beat(MODE_PASS_END, $urandom_range(7), $urandom_range(15), CDATA_W'($urandom));
    end
    wait_idle();

    write_scans(SCAN_W'($urandom_range(8, 2)));
    in_gap_max  = 0;
    out_gap_max = 0;
    add_random_mix(60);
    wait_idle();
    in_gap_max  = 11;
    out_gap_max = 11;
    add_random_mix(60);
    wait_idle();

    $display("debouncer run: %0d beats in, %0d results checked", beats_in, views_checked);
    $display("  %0d matrix commits, %0d bounces, scan settings 5/1/0/255/random",
             commits_seen, bounces_seen);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
